// ----- rtl/core/pimp_pkg.sv -----
package pimp_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxFaces    = 1024;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CntW        = 11;

  localparam logic [1:0] OpWrVtx  = 2'd0;
  localparam logic [1:0] OpWrFace = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [IdxW-1:0]          slot;
    logic signed [CoordW-1:0] x_val;
    logic signed [CoordW-1:0] y_val;
    logic signed [CoordW-1:0] z_val;
    logic [IdxW-1:0]          corner_a;
    logic [IdxW-1:0]          corner_b;
    logic [IdxW-1:0]          corner_c;
  } in_t;

  typedef struct packed {
    logic            inside_res;
    logic [CntW-1:0] crossings;
    logic            status;
  } out_t;

  typedef struct packed {
    logic            wr_vtx;
    logic            wr_face;
    logic            q_start;
    logic            issue;
    logic [IdxW-1:0] issue_idx;
    logic            resp;
    logic            fin;
    logic            st;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

// ----- rtl/core/pimp_ctrl.sv -----
module pimp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic [1:0]            op_i,
  input  logic                  cfg_we_i,
  input  logic [pimp_pkg::CntW-1:0] cfg_wdata_i,
  input  pimp_pkg::stat_t       stat_i,
  output pimp_pkg::cmd_t        cmd_o,
  output logic                  busy
);

  typedef enum logic [1:0] {StIdle, StRun, StDrain} state_e;

  localparam logic [pimp_pkg::CntW-1:0] FaceLim = pimp_pkg::CntW'(pimp_pkg::MaxFaces);

  state_e                      state_q;
  logic [pimp_pkg::CntW-1:0]   fc_q, n_q, idx_q;
  logic                        ovf_q;
  logic                        accept;
  logic [pimp_pkg::CntW-1:0]   n_d;

  assign busy   = (state_q != StIdle);
  assign accept = start && (state_q == StIdle);
  assign n_d    = (fc_q > FaceLim) ? FaceLim : fc_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.issue_idx = idx_q[pimp_pkg::IdxW-1:0];
    cmd_o.st        = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (op_i)
            pimp_pkg::OpWrVtx: begin
              cmd_o.wr_vtx = 1'b1;
              cmd_o.resp   = 1'b1;
              cmd_o.st     = 1'b0;
            end
            pimp_pkg::OpWrFace: begin
              cmd_o.wr_face = 1'b1;
              cmd_o.resp    = 1'b1;
              cmd_o.st      = 1'b0;
            end
            pimp_pkg::OpQuery: begin
              cmd_o.q_start = 1'b1;
            end
            default: begin
              cmd_o.resp = 1'b1;
              cmd_o.st   = 1'b1;
            end
          endcase
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
      end
      StDrain: begin
        cmd_o.fin = !stat_i.pipe_busy;
      end
      default: begin
        cmd_o.fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fc_q    <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fc_q <= cfg_wdata_i;
      end
      unique case (state_q)
        StIdle: begin
          if (accept && (op_i == pimp_pkg::OpQuery)) begin
            n_q     <= n_d;
            idx_q   <= '0;
            ovf_q   <= (fc_q > FaceLim);
            state_q <= (n_d != '0) ? StRun : StDrain;
          end
        end
        StRun: begin
          if (idx_q == n_q - pimp_pkg::CntW'(1)) begin
            state_q <= StDrain;
          end else begin
            idx_q <= idx_q + pimp_pkg::CntW'(1);
          end
        end
        StDrain: begin
          if (!stat_i.pipe_busy) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/pimp_datapath.sv -----
module pimp_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pimp_pkg::in_t     item_i,
  input  pimp_pkg::cmd_t    cmd_i,
  output pimp_pkg::stat_t   stat_o,
  output logic              result_valid_o,
  output pimp_pkg::out_t    result_o
);

  localparam int unsigned CW = pimp_pkg::CoordW;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned MW = NW + DW;
  localparam int unsigned SW = MW + 2;
  localparam int unsigned IW = pimp_pkg::IdxW;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic [IW-1:0] a;
    logic [IW-1:0] b;
    logic [IW-1:0] c;
  } tri_t;

  vtx_t vmem_a [pimp_pkg::MaxVertices];
  vtx_t vmem_b [pimp_pkg::MaxVertices];
  vtx_t vmem_c [pimp_pkg::MaxVertices];
  tri_t fmem   [pimp_pkg::MaxFaces];

  vtx_t q_q;
  logic [7:1] v_q;
  tri_t f_q;
  vtx_t va_q, vb_q, vc_q;

  logic signed [DW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [DW-1:0] qdx_q, qdy_q, qdz_q;
  logic signed [DW-1:0] ex_q [3];
  logic signed [DW-1:0] ey_q [3];
  logic signed [DW-1:0] dx_q [3];
  logic signed [DW-1:0] dy_q [3];

  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [PW-1:0] ka_q [3];
  logic signed [PW-1:0] kb_q [3];
  logic signed [DW-1:0] qdx4_q, qdy4_q, qdz4_q;

  logic signed [NW-1:0] nx_q, ny_q, nz_q;
  logic signed [NW-1:0] cr [3];
  logic [2:0]           cz_q, cn_q;
  logic signed [DW-1:0] qdx5_q, qdy5_q, qdz5_q;

  logic signed [MW-1:0] mx_q, my_q, mz_q;
  logic                 nzz_q, nzn_q, eok;
  logic [2:0]           cz6_q, cn6_q;

  logic signed [SW-1:0] dsum;
  logic                 hit_q;
  logic [pimp_pkg::CntW-1:0] cnt_q;

  assign stat_o.pipe_busy = |v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_vtx) begin
      vmem_a[item_i.slot] <= {item_i.x_val, item_i.y_val, item_i.z_val};
      vmem_b[item_i.slot] <= {item_i.x_val, item_i.y_val, item_i.z_val};
      vmem_c[item_i.slot] <= {item_i.x_val, item_i.y_val, item_i.z_val};
    end
    if (cmd_i.wr_face) begin
      fmem[item_i.slot] <= {item_i.corner_a, item_i.corner_b, item_i.corner_c};
    end
    if (cmd_i.q_start) begin
      q_q <= {item_i.x_val, item_i.y_val, item_i.z_val};
    end
    f_q  <= fmem[cmd_i.issue_idx];
    va_q <= vmem_a[f_q.a];
    vb_q <= vmem_b[f_q.b];
    vc_q <= vmem_c[f_q.c];
  end

  always_ff @(posedge clk_i) begin
    e1x_q <= DW'(vb_q.x) - DW'(va_q.x);
    e1y_q <= DW'(vb_q.y) - DW'(va_q.y);
    e1z_q <= DW'(vb_q.z) - DW'(va_q.z);
    e2x_q <= DW'(vc_q.x) - DW'(va_q.x);
    e2y_q <= DW'(vc_q.y) - DW'(va_q.y);
    e2z_q <= DW'(vc_q.z) - DW'(va_q.z);
    qdx_q <= DW'(q_q.x) - DW'(va_q.x);
    qdy_q <= DW'(q_q.y) - DW'(va_q.y);
    qdz_q <= DW'(q_q.z) - DW'(va_q.z);
    ex_q[0] <= DW'(vb_q.x) - DW'(va_q.x);
    ey_q[0] <= DW'(vb_q.y) - DW'(va_q.y);
    dx_q[0] <= DW'(q_q.x) - DW'(va_q.x);
    dy_q[0] <= DW'(q_q.y) - DW'(va_q.y);
    ex_q[1] <= DW'(vc_q.x) - DW'(vb_q.x);
    ey_q[1] <= DW'(vc_q.y) - DW'(vb_q.y);
    dx_q[1] <= DW'(q_q.x) - DW'(vb_q.x);
    dy_q[1] <= DW'(q_q.y) - DW'(vb_q.y);
    ex_q[2] <= DW'(va_q.x) - DW'(vc_q.x);
    ey_q[2] <= DW'(va_q.y) - DW'(vc_q.y);
    dx_q[2] <= DW'(q_q.x) - DW'(vc_q.x);
    dy_q[2] <= DW'(q_q.y) - DW'(vc_q.y);

    pa_q <= PW'(e1y_q) * PW'(e2z_q);
    pb_q <= PW'(e1z_q) * PW'(e2y_q);
    pc_q <= PW'(e1z_q) * PW'(e2x_q);
    pd_q <= PW'(e1x_q) * PW'(e2z_q);
    pe_q <= PW'(e1x_q) * PW'(e2y_q);
    pf_q <= PW'(e1y_q) * PW'(e2x_q);
    for (int k = 0; k < 3; k++) begin
      ka_q[k] <= PW'(ex_q[k]) * PW'(dy_q[k]);
      kb_q[k] <= PW'(ey_q[k]) * PW'(dx_q[k]);
    end
    qdx4_q <= qdx_q;
    qdy4_q <= qdy_q;
    qdz4_q <= qdz_q;

    nx_q <= NW'(pa_q) - NW'(pb_q);
    ny_q <= NW'(pc_q) - NW'(pd_q);
    nz_q <= NW'(pe_q) - NW'(pf_q);
    for (int k = 0; k < 3; k++) begin
      cz_q[k] <= (cr[k] == '0);
      cn_q[k] <= cr[k][NW-1];
    end
    qdx5_q <= qdx4_q;
    qdy5_q <= qdy4_q;
    qdz5_q <= qdz4_q;

    mx_q  <= MW'(nx_q) * MW'(qdx5_q);
    my_q  <= MW'(ny_q) * MW'(qdy5_q);
    mz_q  <= MW'(nz_q) * MW'(qdz5_q);
    nzz_q <= (nz_q == '0);
    nzn_q <= nz_q[NW-1];
    cz6_q <= cz_q;
    cn6_q <= cn_q;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr[k] = NW'(ka_q[k]) - NW'(kb_q[k]);
    end
    eok  = &(cz6_q | ~(cn6_q ^ {3{nzn_q}}));
    dsum = SW'(mx_q) + SW'(my_q) + SW'(mz_q);
  end

  always_ff @(posedge clk_i) begin
    hit_q <= !nzz_q && (dsum != '0) && (dsum[SW-1] != nzn_q) && eok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q            <= '0;
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      v_q            <= {v_q[6:1], cmd_i.issue};
      result_valid_o <= cmd_i.resp || cmd_i.fin;
      if (cmd_i.q_start) begin
        cnt_q <= '0;
      end else if (v_q[7] && hit_q) begin
        cnt_q <= cnt_q + pimp_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      result_o.inside_res <= cnt_q[0];
      result_o.crossings  <= cnt_q;
      result_o.status     <= cmd_i.st;
    end else begin
      result_o.inside_res <= 1'b0;
      result_o.crossings  <= '0;
      result_o.status     <= cmd_i.st;
    end
  end

endmodule

// ----- rtl/core/point_in_mesh_parity.sv -----
// Vertex writes, face writes and bad operations give their result in the cycle after acceptance,
// and the next item can be accepted while that result is shown.
// A query over F faces, F above zero, feeds one face into the pipeline per cycle, then waits
// for the pipeline to drain before it shows its result; an empty face table skips the feed.
// Busy drops in the cycle the query result is shown. Reset clears control state and face_count;
// vertex and face stores are undefined until written. The receiver cannot stall.
module point_in_mesh_parity (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pimp_pkg::in_t             in_i,
  input  logic                      cfg_we_i,
  input  logic [pimp_pkg::CntW-1:0] cfg_wdata_i,
  output logic                      result_valid_o,
  output pimp_pkg::out_t            result_o
);

  pimp_pkg::cmd_t  cmd;
  pimp_pkg::stat_t stat;

  pimp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .op_i        (in_i.op),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  pimp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
